// File: src/i2c_eeprom_byte_access_master_macros.svh
// Assertion macros used by the byte access master top level.
`ifndef I2C_EEPROM_BYTE_ACCESS_MASTER_MACROS_SVH
`define I2C_EEPROM_BYTE_ACCESS_MASTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define I2CEBM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cebm: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define I2CEBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cebm: next-cycle check failed");

`endif

// File: src/i2cebm_pkg.sv
// Types, codes and the transaction programmes of the byte access master.
package i2cebm_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_PHASE_TICKS    = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd2;

  localparam logic [15:0] PHASE_TICKS_RESET    = 16'd250;
  localparam logic [9:0]  ACK_TIMEOUT_RESET    = 10'd1000;
  localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd80;

  typedef enum logic [4:0] {
    S_IDLE, S_ST_A, S_ST_B, S_ST_C,
    S_BIT_A, S_BIT_B, S_BIT_C, S_TAIL_A, S_TAIL_B,
    S_ACK_H, S_ACK_P, S_ACK_L,
    S_RD_A, S_RD_B, S_RD_H, S_RD_L,
    S_SP_A, S_SP_B, S_SP_C
  } step_t;

  typedef enum logic [3:0] {
    OP_END, OP_START, OP_DEVW, OP_ADDR, OP_DATA, OP_DEVR, OP_ACK, OP_READ, OP_STOP
  } op_t;

  // Operation at a programme slot; write and read programmes
  function automatic op_t prog_op(logic is_read, logic [3:0] slot);
    op_t op;
    op = OP_END;
    if (!is_read) begin
      unique case (slot)
        4'd0:    op = OP_START;
        4'd1:    op = OP_DEVW;
        4'd2:    op = OP_ACK;
        4'd3:    op = OP_ADDR;
        4'd4:    op = OP_ACK;
        4'd5:    op = OP_DATA;
        4'd6:    op = OP_ACK;
        4'd7:    op = OP_STOP;
        default: op = OP_END;
      endcase
    end else begin
      unique case (slot)
        4'd0:    op = OP_START;
        4'd1:    op = OP_DEVW;
        4'd2:    op = OP_ACK;
        4'd3:    op = OP_ADDR;
        4'd4:    op = OP_ACK;
        4'd5:    op = OP_START;
        4'd6:    op = OP_DEVR;
        4'd7:    op = OP_ACK;
        4'd8:    op = OP_READ;
        4'd9:    op = OP_STOP;
        default: op = OP_END;
      endcase
    end
    return op;
  endfunction

endpackage

// File: src/i2c_eeprom_byte_access_master.sv
// Top level of the two-wire EEPROM byte access master.
//
//  channel  | handshake             | word contents
//  ---------+-----------------------+------------------------------------------------
//  in       | in_valid / in_ready   | req_valid req_type mem_address write_data sda_in
//  out      | out_valid / out_ready | scl_level sda_level sda_drive busy_res done_res
//           |                       | read_byte ack_missing
//  cfg      | cfg_write (no wait)   | cfg_index cfg_data
//
// One input word is one bus timer tick; its result word is registered and
// appears on the out port at the next clock edge.
// The sequencer state registers double as the result register, so a new word
// is taken every cycle while out_ready stays high.
// A stalled result (out_valid high, out_ready low) drops in_ready and holds the state.
// Reset (rst, synchronous) returns to idle with both lines driven high
// and the configuration registers at their defaults.
`include "i2c_eeprom_byte_access_master_macros.svh"

module i2c_eeprom_byte_access_master (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_valid,
  input  logic        req_type,
  input  logic [7:0]  mem_address,
  input  logic [7:0]  write_data,
  input  logic        sda_in,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_level,
  output logic        sda_level,
  output logic        sda_drive,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_byte,
  output logic        ack_missing,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [15:0] phase_ticks;
  logic [9:0]  ack_timeout;
  logic [6:0]  device_address;

  // Sequencer state
  i2cebm_pkg::step_t step, step_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [15:0] phase_counter, phase_counter_next;
  logic [9:0]  ack_cnt, ack_cnt_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic        lat_type, lat_type_next;
  logic [7:0]  lat_addr, lat_addr_next;
  logic [7:0]  lat_data, lat_data_next;
  logic [7:0]  received, received_next;
  logic        ack_fault, ack_fault_next;
  logic [3:0]  slot, slot_next;
  logic        line_scl, line_scl_next;
  logic        line_sda, line_sda_next;
  logic        line_drive, line_drive_next;
  logic        finished, finished_next;

  logic accept;
  logic take_request;

  // The result register is the state itself: it may only move with the out side free
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // An accepted word that opens a transaction
  assign take_request = accept && req_valid && (step == i2cebm_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks    <= i2cebm_pkg::PHASE_TICKS_RESET;
      ack_timeout    <= i2cebm_pkg::ACK_TIMEOUT_RESET;
      device_address <= i2cebm_pkg::DEVICE_ADDRESS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        i2cebm_pkg::REG_PHASE_TICKS:    phase_ticks    <= cfg_data;
        i2cebm_pkg::REG_ACK_TIMEOUT:    ack_timeout    <= cfg_data[9:0];
        i2cebm_pkg::REG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Next state for one tick: phase timing, then programme advance, then entry actions
  always_comb begin
    logic [15:0] pc_inc;
    logic [9:0]  lim;
    logic        start_op;
    logic        go;
    logic [3:0]  op_slot;
    i2cebm_pkg::step_t tgt;
    i2cebm_pkg::op_t   op;

    step_next          = step;
    bit_index_next     = bit_index;
    phase_counter_next = phase_counter;
    ack_cnt_next       = ack_cnt;
    shift_byte_next    = shift_byte;
    lat_type_next      = lat_type;
    lat_addr_next      = lat_addr;
    lat_data_next      = lat_data;
    received_next      = received;
    ack_fault_next     = ack_fault;
    slot_next          = slot;
    line_scl_next      = line_scl;
    line_sda_next      = line_sda;
    line_drive_next    = line_drive;
    finished_next      = 1'b0;

    pc_inc   = phase_counter + 16'd1;
    lim      = (ack_timeout == '0) ? 10'd1 : ack_timeout;
    start_op = 1'b0;
    go       = 1'b0;
    op_slot  = slot + 4'd1;
    tgt      = step;
    op       = i2cebm_pkg::OP_END;

    priority if (step == i2cebm_pkg::S_IDLE) begin
      if (req_valid) begin
        lat_type_next  = req_type;
        lat_addr_next  = mem_address;
        lat_data_next  = write_data;
        ack_fault_next = 1'b0;
        start_op       = 1'b1;
        op_slot        = '0;
      end
    end else if (step == i2cebm_pkg::S_ACK_P) begin
      // Poll the acknowledge; a timeout is recorded and the wait ends anyway
      if (!sda_in) begin
        go  = 1'b1;
        tgt = i2cebm_pkg::S_ACK_L;
      end else begin
        if (ack_cnt != '1) ack_cnt_next = ack_cnt + 10'd1;
        if (ack_cnt_next >= lim) begin
          ack_fault_next = 1'b1;
          go             = 1'b1;
          tgt            = i2cebm_pkg::S_ACK_L;
        end
      end
    end else begin
      phase_counter_next = pc_inc;
      if (pc_inc >= phase_ticks) begin
        go = 1'b1;
        unique case (step)
          i2cebm_pkg::S_ST_A:  tgt = i2cebm_pkg::S_ST_B;
          i2cebm_pkg::S_ST_B:  tgt = i2cebm_pkg::S_ST_C;
          i2cebm_pkg::S_BIT_A: tgt = i2cebm_pkg::S_BIT_B;
          i2cebm_pkg::S_BIT_B: tgt = i2cebm_pkg::S_BIT_C;
          i2cebm_pkg::S_BIT_C: begin
            if (bit_index != 3'd7) begin
              bit_index_next = bit_index + 3'd1;
              tgt            = i2cebm_pkg::S_BIT_A;
            end else begin
              tgt = i2cebm_pkg::S_TAIL_A;
            end
          end
          i2cebm_pkg::S_TAIL_A: tgt = i2cebm_pkg::S_TAIL_B;
          i2cebm_pkg::S_ACK_H:  tgt = i2cebm_pkg::S_ACK_P;
          i2cebm_pkg::S_RD_A:   tgt = i2cebm_pkg::S_RD_B;
          i2cebm_pkg::S_RD_B:   tgt = i2cebm_pkg::S_RD_H;
          i2cebm_pkg::S_RD_H: begin
            // Sample on the last tick of clock high
            shift_byte_next = {shift_byte[6:0], sda_in};
            tgt             = i2cebm_pkg::S_RD_L;
          end
          i2cebm_pkg::S_RD_L: begin
            if (bit_index != 3'd7) begin
              bit_index_next = bit_index + 3'd1;
              tgt            = i2cebm_pkg::S_RD_H;
            end else begin
              go       = 1'b0;
              start_op = 1'b1;
            end
          end
          i2cebm_pkg::S_SP_A: tgt = i2cebm_pkg::S_SP_B;
          i2cebm_pkg::S_SP_B: tgt = i2cebm_pkg::S_SP_C;
          default: begin
            // end of start, byte tail, acknowledge or stop: next operation
            go       = 1'b0;
            start_op = 1'b1;
          end
        endcase
      end
    end

    if (start_op) begin
      slot_next = op_slot;
      op        = i2cebm_pkg::prog_op(lat_type_next, op_slot);
      go        = 1'b1;
      unique case (op)
        i2cebm_pkg::OP_START: tgt = i2cebm_pkg::S_ST_A;
        i2cebm_pkg::OP_DEVW: begin
          shift_byte_next = {device_address, 1'b0};
          bit_index_next  = '0;
          tgt             = i2cebm_pkg::S_BIT_A;
        end
        i2cebm_pkg::OP_DEVR: begin
          shift_byte_next = {device_address, 1'b1};
          bit_index_next  = '0;
          tgt             = i2cebm_pkg::S_BIT_A;
        end
        i2cebm_pkg::OP_ADDR: begin
          shift_byte_next = lat_addr_next;
          bit_index_next  = '0;
          tgt             = i2cebm_pkg::S_BIT_A;
        end
        i2cebm_pkg::OP_DATA: begin
          shift_byte_next = lat_data_next;
          bit_index_next  = '0;
          tgt             = i2cebm_pkg::S_BIT_A;
        end
        i2cebm_pkg::OP_ACK: tgt = i2cebm_pkg::S_ACK_H;
        i2cebm_pkg::OP_READ: begin
          shift_byte_next = '0;
          bit_index_next  = '0;
          tgt             = i2cebm_pkg::S_RD_A;
        end
        i2cebm_pkg::OP_STOP: tgt = i2cebm_pkg::S_SP_A;
        default: begin
          // programme finished: return to idle, lines stay as they are
          go = 1'b0;
          if (lat_type_next) received_next = shift_byte_next;
          step_next          = i2cebm_pkg::S_IDLE;
          phase_counter_next = '0;
          finished_next      = 1'b1;
        end
      endcase
    end

    if (go) begin
      step_next          = tgt;
      phase_counter_next = '0;
      unique case (tgt)
        i2cebm_pkg::S_ST_A: begin
          line_sda_next   = 1'b1;
          line_drive_next = 1'b1;
        end
        i2cebm_pkg::S_ST_B:  line_scl_next = 1'b1;
        i2cebm_pkg::S_ST_C:  line_sda_next = 1'b0;
        i2cebm_pkg::S_BIT_A: begin
          line_scl_next   = 1'b0;
          line_drive_next = 1'b1;
        end
        // ~bit_index picks bits MSB first
        i2cebm_pkg::S_BIT_B:  line_sda_next = shift_byte_next[~bit_index_next];
        i2cebm_pkg::S_BIT_C:  line_scl_next = 1'b1;
        i2cebm_pkg::S_TAIL_A: line_scl_next = 1'b0;
        i2cebm_pkg::S_TAIL_B: line_sda_next = 1'b1;
        i2cebm_pkg::S_ACK_H: begin
          line_drive_next = 1'b0;
          line_scl_next   = 1'b1;
        end
        i2cebm_pkg::S_ACK_P: ack_cnt_next  = '0;
        i2cebm_pkg::S_ACK_L: line_scl_next = 1'b0;
        i2cebm_pkg::S_RD_A: begin
          line_drive_next = 1'b1;
          line_scl_next   = 1'b0;
        end
        i2cebm_pkg::S_RD_B: line_sda_next = 1'b1;
        i2cebm_pkg::S_RD_H: begin
          line_drive_next = 1'b0;
          line_scl_next   = 1'b1;
        end
        i2cebm_pkg::S_RD_L: line_scl_next = 1'b0;
        i2cebm_pkg::S_SP_A: begin
          line_drive_next = 1'b1;
          line_sda_next   = 1'b0;
        end
        i2cebm_pkg::S_SP_B: line_scl_next = 1'b1;
        i2cebm_pkg::S_SP_C: line_sda_next = 1'b1;
        default: ;
      endcase
    end
  end

  // Advance the state on every accepted word; hold it otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= i2cebm_pkg::S_IDLE;
      bit_index     <= '0;
      phase_counter <= '0;
      ack_cnt       <= '0;
      shift_byte    <= '0;
      lat_type      <= 1'b0;
      lat_addr      <= '0;
      lat_data      <= '0;
      received      <= '0;
      ack_fault     <= 1'b0;
      slot          <= '0;
      line_scl      <= 1'b1;
      line_sda      <= 1'b1;
      line_drive    <= 1'b1;
      finished      <= 1'b0;
    end else if (accept) begin
      step          <= step_next;
      bit_index     <= bit_index_next;
      phase_counter <= phase_counter_next;
      ack_cnt       <= ack_cnt_next;
      shift_byte    <= shift_byte_next;
      lat_type      <= lat_type_next;
      lat_addr      <= lat_addr_next;
      lat_data      <= lat_data_next;
      received      <= received_next;
      ack_fault     <= ack_fault_next;
      slot          <= slot_next;
      line_scl      <= line_scl_next;
      line_sda      <= line_sda_next;
      line_drive    <= line_drive_next;
      finished      <= finished_next;
    end
  end

  // One result word per accepted input word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign scl_level   = line_scl;
  assign sda_level   = line_sda;
  assign sda_drive   = line_drive;
  assign busy_res    = (step != i2cebm_pkg::S_IDLE);
  assign done_res    = finished;
  assign read_byte   = received;
  assign ack_missing = ack_fault;

  `I2CEBM_ASSERT_NOW(a_done_is_idle, clk, rst, done_res, !busy_res)
  `I2CEBM_ASSERT_NOW(a_ack_poll_lines, clk, rst, step == i2cebm_pkg::S_ACK_P, !sda_drive && scl_level)
  `I2CEBM_ASSERT_NEXT(a_stall_holds_state, clk, rst, !in_ready, $stable(step) && $stable(phase_counter))
  `I2CEBM_ASSERT_NEXT(a_request_starts, clk, rst, take_request, step == i2cebm_pkg::S_ST_A)

endmodule
